// ===== rtl/uart_line_framer_ring_top_macros.svh =====
// ----------------------------------------------------------------------------
// uart line framer ring assertion macros
// concurrent assertion shorthands used by the framer engine
// ----------------------------------------------------------------------------
`ifndef UART_LINE_FRAMER_RING_TOP_MACROS_SVH
`define UART_LINE_FRAMER_RING_TOP_MACROS_SVH

// condition holds at every edge outside reset
`define ULFR_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ULFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ulfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ulfr_pkg
// shared types, sizes and byte codes of the line framer
// ----------------------------------------------------------------------------
package ulfr_pkg;

   localparam int LINE_SLOTS  = 8;
   localparam int LINE_BYTES  = 64;
   localparam int SLOT_W      = $clog2(LINE_SLOTS);
   localparam int POS_W       = $clog2(LINE_BYTES);
   localparam int ADDR_W      = SLOT_W + POS_W;
   localparam int STORE_DEPTH = LINE_SLOTS * (2 ** POS_W);
   localparam int LEN_W       = 7;
   localparam int CSR_INDEX_W = 3;

   localparam logic [LEN_W-1:0] LINE_BYTES_LEN = LEN_W'(LINE_BYTES);

   localparam logic [7:0] HDR_SYNC = 8'h55;
   localparam logic [7:0] CODE_H   = 8'h48;
   localparam logic [7:0] CODE_R   = 8'h52;
   localparam logic [7:0] CODE_E   = 8'h45;
   localparam logic [7:0] CODE_F   = 8'h46;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMING_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_LENGTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_LENGTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_FLAG     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_LENGTH   = 3'd5;

   typedef enum logic {
      CMD_RECEIVE = 1'b0,
      CMD_READ    = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type          command;
      logic [7:0]       rx_byte;
      logic [LEN_W-1:0] read_limit;
   } req_type;

   typedef struct packed {
      logic             framing_mode;
      logic [LEN_W-1:0] ack_length;
      logic [LEN_W-1:0] info_length;
      logic [LEN_W-1:0] full_packet_length;
      logic             final_packet_flag;
      logic [LEN_W-1:0] final_packet_length;
   } cfg_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(LINE_SLOTS - 1)) r = '0;
      else r = s + SLOT_W'(1);
      return r;
   endfunction

endpackage

// ===== rtl/ulfr_if.sv =====
// ----------------------------------------------------------------------------
// ulfr channel interfaces
// valid/ready channels for requests and line bytes
// ----------------------------------------------------------------------------
interface ulfr_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;
   logic [6:0] read_limit;
   modport source (output valid, command, rx_byte, read_limit, input ready);
   modport sink   (input valid, command, rx_byte, read_limit, output ready);
endinterface

interface ulfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic [6:0] line_length;
   logic       read_status;
   logic       last_of_line;
   modport source (output valid, line_byte, line_length, read_status, last_of_line,
                   input ready);
   modport sink   (input valid, line_byte, line_length, read_status, last_of_line,
                   output ready);
endinterface

// ===== rtl/ulfr_ram.sv =====
// ----------------------------------------------------------------------------
// ulfr_ram
// generic one write, one read port ram with registered read
// ----------------------------------------------------------------------------
module ulfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) mem_ff[write_addr] <= write_data;
      if (read_enable) read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;
endmodule

// ===== rtl/ulfr_front.sv =====
// ----------------------------------------------------------------------------
// ulfr_front
// request intake, command decode and two entry queue
// ----------------------------------------------------------------------------
module ulfr_front (
   input  logic             clock,
   input  logic             reset,
   ulfr_req_if.sink         req_ch,
   output logic             q_valid,
   output ulfr_pkg::req_type q_head,
   input  logic             q_pop
);
   import ulfr_pkg::*;

   req_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   req_type    decoded;

   always_comb begin
      decoded.command    = req_ch.command ? CMD_READ : CMD_RECEIVE;
      decoded.rx_byte    = req_ch.rx_byte;
      decoded.read_limit = req_ch.read_limit;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != 2'd0);
   assign q_head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= decoded;
   end
endmodule

// ===== rtl/ulfr_back.sv =====
// ----------------------------------------------------------------------------
// ulfr_back
// framing engine: stores received bytes, streams out whole lines
// ----------------------------------------------------------------------------
`include "uart_line_framer_ring_top_macros.svh"

module ulfr_back (
   input  logic              clock,
   input  logic              reset,
   input  ulfr_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  ulfr_pkg::req_type q_head,
   output logic              q_pop,
   ulfr_rsp_if.source        rsp_ch
);
   import ulfr_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_READ = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] ws_ff, ws_in;
   logic [LEN_W-1:0]  wp_ff, wp_in;
   logic [SLOT_W-1:0] rs_ff, rs_in;
   logic [LEN_W-1:0]  exp_ff, exp_in;
   logic [7:0]        prev_ff, prev_in;
   logic [LEN_W-1:0]  slot_len_ff [LINE_SLOTS];
   logic [LEN_W-1:0]  slot_len_in [LINE_SLOTS];
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [POS_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              rd_pending_ff, rd_pending_in;
   logic              rd_last_ff, rd_last_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic              out_status_ff, out_status_in;
   logic              out_last_ff, out_last_in;

   logic              out_free, move, issue, idle_ok, single;
   logic [LEN_W-1:0]  cur_len, n_min, wp_inc, wp_a, exp_sel, exp_use, commit_len;
   logic              hdr, bad, term, commit;
   logic [SLOT_W-1:0] ws_next;
   logic [7:0]        b;
   logic [7:0]        ram_rdata;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign move     = rd_pending_ff && out_free;
   assign issue    = (state_ff == BK_READ) && (!rd_pending_ff || move);
   assign idle_ok  = (state_ff == BK_IDLE) && !rd_pending_ff;
   assign cur_len  = slot_len_ff[rs_ff];
   assign n_min    = (q_head.read_limit < cur_len) ? q_head.read_limit : cur_len;
   assign single   = (cur_len == '0) || (n_min == '0);
   assign q_pop    = q_valid && idle_ok &&
                     (q_head.command == CMD_RECEIVE || !single || out_free);
   assign b        = q_head.rx_byte;

   // receive framing decisions
   always_comb begin
      wp_inc = wp_ff + LEN_W'(1);
      if (b == CODE_H || b == CODE_E) exp_sel = cfg.ack_length;
      else if (b == CODE_R) exp_sel = cfg.info_length;
      else if (b == CODE_F && cfg.final_packet_flag) exp_sel = cfg.final_packet_length;
      else exp_sel = cfg.full_packet_length;
      hdr        = (wp_inc == LEN_W'(2));
      bad        = hdr && (prev_ff != HDR_SYNC);
      term       = (b == CH_LF) && (wp_inc >= LEN_W'(2)) && (prev_ff == CH_CR);
      exp_use    = exp_ff;
      wp_a       = wp_inc;
      commit     = 1'b0;
      commit_len = wp_inc;
      if (!cfg.framing_mode) begin
         if (hdr && !bad) exp_use = exp_sel;
         if (bad) wp_a = '0;
         if (wp_a != '0 && wp_a == exp_use) begin
            commit     = 1'b1;
            commit_len = wp_a;
         end
      end else if (term) begin
         if (wp_inc == LEN_W'(2)) wp_a = '0;
         else begin
            commit     = 1'b1;
            commit_len = wp_inc - LEN_W'(2);
         end
      end
      if (!commit && wp_a == LINE_BYTES_LEN) begin
         commit     = 1'b1;
         commit_len = wp_a;
      end
      ws_next = next_slot(ws_ff);
   end

   always_comb begin
      state_in      = state_ff;
      ws_in         = ws_ff;
      wp_in         = wp_ff;
      rs_in         = rs_ff;
      exp_in        = exp_ff;
      prev_in       = prev_ff;
      slot_len_in   = slot_len_ff;
      rd_slot_in    = rd_slot_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      len_in        = len_ff;
      rd_pending_in = rd_pending_ff;
      rd_last_in    = rd_last_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_len_in    = out_len_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (out_valid_ff && rsp_ch.ready) out_valid_in = 1'b0;
      if (move) begin
         out_valid_in  = 1'b1;
         out_byte_in   = ram_rdata;
         out_len_in    = len_ff;
         out_status_in = 1'b0;
         out_last_in   = rd_last_ff;
         rd_pending_in = 1'b0;
      end
      if (issue) begin
         rd_pending_in = 1'b1;
         rd_last_in    = ({1'b0, cnt_ff} + LEN_W'(1) == n_ff);
         cnt_in        = cnt_ff + POS_W'(1);
         if ({1'b0, cnt_ff} + LEN_W'(1) == n_ff) state_in = BK_IDLE;
      end

      if (q_pop && q_head.command == CMD_RECEIVE) begin
         prev_in = b;
         if (!cfg.framing_mode) exp_in = exp_use;
         wp_in = wp_a;
         if (commit) begin
            wp_in = '0;
            if (slot_len_ff[ws_next] != '0) begin
               // ring full: the newest line is dropped and its slot reused
               slot_len_in[ws_ff] = '0;
            end else begin
               slot_len_in[ws_ff] = commit_len;
               ws_in = ws_next;
            end
         end
      end else if (q_pop) begin
         if (cur_len != '0) begin
            slot_len_in[rs_ff] = '0;
            rs_in = next_slot(rs_ff);
         end
         if (single) begin
            out_valid_in  = 1'b1;
            out_byte_in   = '0;
            out_len_in    = cur_len;
            out_status_in = (cur_len == '0);
            out_last_in   = 1'b1;
         end else begin
            state_in   = BK_READ;
            rd_slot_in = rs_ff;
            cnt_in     = '0;
            n_in       = n_min;
            len_in     = cur_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         ws_ff         <= '0;
         wp_ff         <= '0;
         rs_ff         <= '0;
         exp_ff        <= LEN_W'(63);
         rd_pending_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < LINE_SLOTS; i++) slot_len_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         ws_ff         <= ws_in;
         wp_ff         <= wp_in;
         rs_ff         <= rs_in;
         exp_ff        <= exp_in;
         rd_pending_ff <= rd_pending_in;
         out_valid_ff  <= out_valid_in;
         slot_len_ff   <= slot_len_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      rd_slot_ff    <= rd_slot_in;
      cnt_ff        <= cnt_in;
      n_ff          <= n_in;
      len_ff        <= len_in;
      rd_last_ff    <= rd_last_in;
      out_byte_ff   <= out_byte_in;
      out_len_ff    <= out_len_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   ulfr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock        (clock),
      .write_enable (q_pop && q_head.command == CMD_RECEIVE),
      .write_addr   ({ws_ff, wp_ff[POS_W-1:0]}),
      .write_data   (b),
      .read_enable  (issue),
      .read_addr    ({rd_slot_ff, cnt_ff}),
      .read_data    (ram_rdata)
   );

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.line_byte    = out_byte_ff;
   assign rsp_ch.line_length  = out_len_ff;
   assign rsp_ch.read_status  = out_status_ff;
   assign rsp_ch.last_of_line = out_last_ff;

   `ULFR_ASSERT_ALWAYS(a_write_slot_free, slot_len_ff[ws_ff] == '0, "write slot holds a line")
   `ULFR_ASSERT_ALWAYS(a_position_range, wp_ff < LINE_BYTES_LEN, "write position at capacity")
   `ULFR_ASSERT_NEXT(a_issue_pending, issue, rd_pending_ff, "issued read not pending")
   `ULFR_ASSERT_ALWAYS(a_no_pop_in_read, !(q_pop && state_ff == BK_READ), "pop during line read")
endmodule

// ===== rtl/uart_line_framer_ring_top.sv =====
// a receive request leaves no response; a read's bytes pass the ram read register and the
// output register; an empty-ring or zero-limit read answers from the output register alone
// throughput: one receive per cycle while the engine is idle; a read streams one line byte
// per cycle while rsp_ch is ready; the pop, ram reads and last hand-off hold the engine
// reset: synchronous active high; ring empty, slots and positions zero, registers at defaults
// ----------------------------------------------------------------------------
// uart_line_framer_ring_top
// frames received bytes into a ring of line slots and hands out whole lines
// ----------------------------------------------------------------------------
module uart_line_framer_ring_top (
   input  logic                              clock,
   input  logic                              reset,
   ulfr_req_if.sink                          req_ch,
   ulfr_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [ulfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ulfr_pkg::LEN_W-1:0]        csr_write_data
);
   import ulfr_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // front to back queue head
   logic    q_valid;
   req_type q_head;
   logic    q_pop;

   // register writes, values masked to width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAMING_MODE: cfg_in.framing_mode        = csr_write_data[0];
            CSR_ACK_LENGTH:   cfg_in.ack_length          = csr_write_data;
            CSR_INFO_LENGTH:  cfg_in.info_length         = csr_write_data;
            CSR_FULL_LENGTH:  cfg_in.full_packet_length  = csr_write_data;
            CSR_FINAL_FLAG:   cfg_in.final_packet_flag   = csr_write_data[0];
            CSR_FINAL_LENGTH: cfg_in.final_packet_length = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.framing_mode        <= 1'b1;
         cfg_ff.ack_length          <= LEN_W'(6);
         cfg_ff.info_length         <= LEN_W'(12);
         cfg_ff.full_packet_length  <= LEN_W'(63);
         cfg_ff.final_packet_flag   <= 1'b0;
         cfg_ff.final_packet_length <= LEN_W'(63);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: takes requests, decodes the command, queues them
   ulfr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // back: frames bytes into the ring and streams lines out
   ulfr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );
endmodule
